/* rtl/core/ktmp_pkg.sv */
// shared types, constants and profit arithmetic for the k-transaction profit unit
package ktmp_pkg;

  localparam int MAX_TRADES_DEFAULT = 16;
  localparam int PRICE_W = 16;
  localparam int PROFIT_W = 32;
  localparam int BEST_W = 31;
  localparam int LIMIT_W = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic signed [PROFIT_W-1:0] PROFIT_TOP = 32'sh7fffffff;
  localparam logic signed [PROFIT_W-1:0] PROFIT_FLOOR = 32'sh80000001;

  localparam logic [LIMIT_W-1:0] MAX_TRADES_RESET = 5'd1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TRADES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNLIMITED = 1'b1;

  // one price travelling down the level chain
  typedef struct packed {
    logic valid;
    logic [PRICE_W-1:0] price;
    logic first;
    logic last;
    logic signed [PROFIT_W-1:0] below;
    logic [BEST_W-1:0] result;
  } ktmp_item_t;

  function automatic logic signed [PROFIT_W-1:0] clamp_profit(
    input logic signed [PROFIT_W+1:0] v
  );
    logic signed [PROFIT_W+1:0] top;
    logic signed [PROFIT_W+1:0] floor;
    logic signed [PROFIT_W-1:0] r;
    top = {{2{PROFIT_TOP[PROFIT_W-1]}}, PROFIT_TOP};
    floor = {{2{PROFIT_FLOOR[PROFIT_W-1]}}, PROFIT_FLOOR};
    if (v > top) begin
      r = PROFIT_TOP;
    end else if (v < floor) begin
      r = PROFIT_FLOOR;
    end else begin
      r = v[PROFIT_W-1:0];
    end
    return r;
  endfunction

  // sell: max(cash, hold + price)
  function automatic logic signed [PROFIT_W-1:0] sell_update(
    input logic signed [PROFIT_W-1:0] cash,
    input logic signed [PROFIT_W-1:0] hold,
    input logic [PRICE_W-1:0] price
  );
    logic signed [PROFIT_W+1:0] a;
    logic signed [PROFIT_W+1:0] b;
    a = {{2{cash[PROFIT_W-1]}}, cash};
    b = {{2{hold[PROFIT_W-1]}}, hold} + $signed({{(PROFIT_W+2-PRICE_W){1'b0}}, price});
    return clamp_profit((b > a) ? b : a);
  endfunction

  // buy: max(hold, below - price)
  function automatic logic signed [PROFIT_W-1:0] buy_update(
    input logic signed [PROFIT_W-1:0] hold,
    input logic signed [PROFIT_W-1:0] below,
    input logic [PRICE_W-1:0] price
  );
    logic signed [PROFIT_W+1:0] a;
    logic signed [PROFIT_W+1:0] b;
    a = {{2{hold[PROFIT_W-1]}}, hold};
    b = {{2{below[PROFIT_W-1]}}, below} - $signed({{(PROFIT_W+2-PRICE_W){1'b0}}, price});
    return clamp_profit((b > a) ? b : a);
  endfunction

endpackage

/* rtl/core/k_transaction_max_profit_unit.sv */
// best k-transaction trading profit over a price stream, chain of per-level cells
// each transaction passes through the registered level cells and then the open-stage output register
// accepts one transaction per cycle while the output is not stalled
// a stalled output freezes the whole level chain and the input side together
// rst clears the pipeline, restores all levels to zero cash and floor hold,
// and sets max_trades to 1 and unlimited_mode to 0
module k_transaction_max_profit_unit
  import ktmp_pkg::*;
#(
  parameter int MAX_TRADES = MAX_TRADES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,   // price
  input  logic [0:0] s_tuser,    // first_price
  input  logic s_tlast,          // last_price
  output logic m_tvalid,
  input  logic m_tready,
  output logic [31:0] m_tdata,   // best_profit, zero pad
  output logic m_tlast,          // sequence_done
  input  logic cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int LEVEL_W = $clog2(MAX_TRADES + 1);
  localparam int CMP_W = (LEVEL_W > LIMIT_W) ? LEVEL_W : LIMIT_W;

  logic [LIMIT_W-1:0] max_trades;
  logic unlimited_mode;
  logic advance;
  logic [CMP_W-1:0] k_wide;
  logic [CMP_W-1:0] k_eff;
  logic [LEVEL_W-1:0] level_sel;
  logic [BEST_W-1:0] best;
  logic [MAX_TRADES:1] chain_valid;
  ktmp_item_t chain [0:MAX_TRADES];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_trades <= MAX_TRADES_RESET;
      unlimited_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_TRADES: max_trades <= cfg_wdata;
        CFG_UNLIMITED:  unlimited_mode <= cfg_wdata[0];
      endcase
    end
  end

  always_comb begin
    k_wide = CMP_W'(max_trades);
    k_eff = (k_wide > CMP_W'(MAX_TRADES)) ? CMP_W'(MAX_TRADES) : k_wide;
    level_sel = k_eff[LEVEL_W-1:0];
  end

  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_comb begin
    chain[0].valid = s_tvalid;
    chain[0].price = s_tdata;
    chain[0].first = s_tuser[0];
    chain[0].last = s_tlast;
    chain[0].below = '0;
    chain[0].result = '0;
  end

  genvar j;
  generate
    for (j = 0; j < MAX_TRADES; j++) begin : g_level
      ktmp_level_cell #(
        .LEVEL_W(LEVEL_W),
        .LEVEL(j + 1)
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .en(advance),
        .level_sel(level_sel),
        .in_item(chain[j]),
        .out_item(chain[j+1])
      );
    end
    for (j = 1; j <= MAX_TRADES; j++) begin : g_valid
      assign chain_valid[j] = chain[j].valid;
    end
  endgenerate

  ktmp_open_stage u_open (
    .clk(clk),
    .rst(rst),
    .en(advance),
    .unlimited_mode(unlimited_mode),
    .in_item(chain[MAX_TRADES]),
    .out_valid(m_tvalid),
    .out_best(best),
    .out_last(m_tlast)
  );

  assign m_tdata = {1'b0, best};

`ifndef ASSERT_OFF
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_tvalid && chain_valid[MAX_TRADES:1] == '0)
    else $error("pipeline not empty after reset");

  a_chain_frozen : assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(chain_valid[MAX_TRADES:1]) && m_tvalid)
    else $error("level chain moved while output stalled");

  a_out_stable : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result transaction changed while stalled");
`endif

endmodule

/* rtl/core/ktmp_level_cell.sv */
// one trade level of the chain: keeps cash and hold profit, passes the transaction on
module ktmp_level_cell
  import ktmp_pkg::*;
#(
  parameter int LEVEL_W = 5,
  parameter int LEVEL = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [LEVEL_W-1:0] level_sel,
  input  ktmp_item_t in_item,
  output ktmp_item_t out_item
);

  logic signed [PROFIT_W-1:0] cash;
  logic signed [PROFIT_W-1:0] hold;
  logic signed [PROFIT_W-1:0] cash_cur;
  logic signed [PROFIT_W-1:0] hold_cur;
  logic signed [PROFIT_W-1:0] cash_next;
  logic signed [PROFIT_W-1:0] hold_next;
  logic [BEST_W-1:0] result_next;

  always_comb begin
    cash_cur = in_item.first ? '0 : cash;
    hold_cur = in_item.first ? PROFIT_FLOOR : hold;
    cash_next = sell_update(cash_cur, hold_cur, in_item.price);
    hold_next = buy_update(hold_cur, in_item.below, in_item.price);
    result_next = (level_sel == LEVEL_W'(LEVEL)) ? cash_next[BEST_W-1:0] : in_item.result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cash <= '0;
      hold <= PROFIT_FLOOR;
      out_item.valid <= 1'b0;
    end else if (en) begin
      out_item.valid <= in_item.valid;
      if (in_item.valid) begin
        cash <= cash_next;
        hold <= hold_next;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      out_item.price <= in_item.price;
      out_item.first <= in_item.first;
      out_item.last <= in_item.last;
      out_item.below <= cash_cur;
      out_item.result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_restart_level : assert property (@(posedge clk) disable iff (rst)
    en && in_item.valid && in_item.first |=>
      cash == '0 &&
      hold == -$signed({{(PROFIT_W-PRICE_W){1'b0}}, $past(in_item.price)}))
    else $error("level did not restart on first price");

  a_cash_nonneg : assert property (@(posedge clk) disable iff (rst)
    !cash[PROFIT_W-1])
    else $error("cash profit went negative");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cash) && $stable(hold) && $stable(out_item.valid))
    else $error("level changed during stall");
`endif

endmodule

/* rtl/core/ktmp_open_stage.sv */
// unlimited-trade profit and output register at the end of the chain
module ktmp_open_stage
  import ktmp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic unlimited_mode,
  input  ktmp_item_t in_item,
  output logic out_valid,
  output logic [BEST_W-1:0] out_best,
  output logic out_last
);

  logic signed [PROFIT_W-1:0] open_cash;
  logic signed [PROFIT_W-1:0] open_hold;
  logic signed [PROFIT_W-1:0] cash_cur;
  logic signed [PROFIT_W-1:0] hold_cur;
  logic signed [PROFIT_W-1:0] open_cash_next;
  logic signed [PROFIT_W-1:0] open_hold_next;

  always_comb begin
    cash_cur = in_item.first ? '0 : open_cash;
    hold_cur = in_item.first ? PROFIT_FLOOR : open_hold;
    open_cash_next = sell_update(cash_cur, hold_cur, in_item.price);
    open_hold_next = buy_update(hold_cur, cash_cur, in_item.price);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_cash <= '0;
      open_hold <= PROFIT_FLOOR;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_item.valid;
      if (in_item.valid) begin
        open_cash <= open_cash_next;
        open_hold <= open_hold_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_best <= unlimited_mode ? open_cash_next[BEST_W-1:0] : in_item.result;
      out_last <= in_item.last;
    end
  end

endmodule

/* tb/sv/k_transaction_max_profit_unit_checker.sv */
// channel monitor, profit predictor and result comparison for the k-transaction profit unit
module k_transaction_max_profit_unit_checker
  import ktmp_pkg::*;
#(
  parameter int MAX_TRADES = MAX_TRADES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [15:0] s_tdata,   // price
  input  logic [0:0] s_tuser,    // first_price
  input  logic s_tlast,          // last_price
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [31:0] m_tdata,   // best_profit, zero pad
  input  logic m_tlast,          // sequence_done
  input  logic cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output int mismatches,
  output int in_flight
);

  typedef struct {
    logic [BEST_W-1:0] profit;
    logic done;
  } outcome_t;

  outcome_t expected_profits[$];

  logic signed [PROFIT_W-1:0] cash_lvl [MAX_TRADES];
  logic signed [PROFIT_W-1:0] hold_lvl [MAX_TRADES];
  logic signed [PROFIT_W-1:0] free_cash;
  logic signed [PROFIT_W-1:0] free_hold;
  logic [LIMIT_W-1:0] trade_limit;
  logic unlimited;

  function automatic logic signed [PROFIT_W-1:0] bound(input longint v);
    if (v > longint'(PROFIT_TOP)) return PROFIT_TOP;
    if (v < longint'(PROFIT_FLOOR)) return PROFIT_FLOOR;
    return v[PROFIT_W-1:0];
  endfunction

  function automatic longint pick(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  task automatic restart_levels();
    for (int j = 0; j < MAX_TRADES; j++) begin
      cash_lvl[j] = '0;
      hold_lvl[j] = PROFIT_FLOOR;
    end
    free_cash = '0;
    free_hold = PROFIT_FLOOR;
  endtask

  // one price through every level, lower levels still hold their old cash
  task automatic trade_price(input logic [15:0] price, input logic first,
                             output logic [BEST_W-1:0] profit);
    longint p;
    longint below;
    longint next_cash;
    longint next_hold;
    longint prev;
    longint best;
    int k;
    p = price;
    if (first) restart_levels();
    for (int j = MAX_TRADES - 1; j >= 0; j--) begin
      below = (j == 0) ? 64'sd0 : longint'(cash_lvl[j - 1]);
      next_cash = pick(cash_lvl[j], longint'(hold_lvl[j]) + p);
      next_hold = pick(hold_lvl[j], below - p);
      cash_lvl[j] = bound(next_cash);
      hold_lvl[j] = bound(next_hold);
    end
    prev = free_cash;
    free_cash = bound(pick(free_cash, longint'(free_hold) + p));
    free_hold = bound(pick(free_hold, prev - p));
    if (unlimited) begin
      best = free_cash;
    end else begin
      k = (trade_limit > MAX_TRADES) ? MAX_TRADES : int'(trade_limit);
      best = (k == 0) ? 64'sd0 : longint'(cash_lvl[k - 1]);
    end
    if (best < 0) best = 0;
    profit = best[BEST_W-1:0];
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t fresh;
    logic [BEST_W-1:0] profit;
    if (rst) begin
      restart_levels();
      trade_limit = MAX_TRADES_RESET;
      unlimited = 1'b0;
      expected_profits.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_TRADES: trade_limit = cfg_wdata;
          CFG_UNLIMITED: unlimited = cfg_wdata[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_profits.size() == 0) begin
          $error("unexpected result transaction: best_profit %0d, sequence_done %0b",
                 m_tdata[BEST_W-1:0], m_tlast);
          mismatches++;
        end else begin
          want = expected_profits.pop_front();
          if (m_tdata[BEST_W-1:0] !== want.profit) begin
            $error("best_profit: expected %0d, got %0d", want.profit, m_tdata[BEST_W-1:0]);
            mismatches++;
          end
          if (m_tlast !== want.done) begin
            $error("sequence_done: expected %0b, got %0b", want.done, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        trade_price(s_tdata, s_tuser[0], profit);
        fresh.profit = profit;
        fresh.done = s_tlast;
        expected_profits.push_back(fresh);
      end
    end
    in_flight = expected_profits.size();
  end

endmodule

/* tb/sv/k_transaction_max_profit_unit_tb.sv */
// stimulus, flow control and verdict for the k-transaction profit unit
module k_transaction_max_profit_unit_tb;
  import ktmp_pkg::*;

  localparam int LEVELS = MAX_TRADES_DEFAULT;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 105;
  localparam int SAT_PAIRS = 20;

  localparam int RX_FREE = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_PATTERN = 2;

  localparam int BREAK_NO_FIRST = 0;
  localparam int BREAK_NO_LAST = 1;
  localparam int BREAK_RESTART = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;     // price
  logic [0:0] s_tuser = '0;      // first_price
  logic s_tlast = 1'b0;          // last_price
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;          // best_profit, zero pad
  logic m_tlast;                 // sequence_done
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MAX_TRADES;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  int mismatches;
  int in_flight;
  int rx_style = RX_RANDOM;
  logic hold_req = 1'b0;
  logic pace_gaps = 1'b1;
  int burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  k_transaction_max_profit_unit #(.MAX_TRADES(LEVELS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  k_transaction_max_profit_unit_checker #(.MAX_TRADES(LEVELS)) profit_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  initial begin : receiver
    int rx_tick;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      rx_tick++;
      case (rx_style)
        RX_FREE: m_tready = 1'b1;
        RX_RANDOM: m_tready = ($urandom_range(0, 3) != 0);
        default: m_tready = ((rx_tick % 13) < 8);
      endcase
    end
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_price(input logic [15:0] price, input logic first, input logic last);
    s_tvalid = 1'b1;
    s_tdata = price;
    s_tuser = first;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic offer_price(input logic [15:0] price, input logic first, input logic last);
    if (pace_gaps) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    send_price(price, first, last);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain_idle();
    while (in_flight != 0) @(negedge clk);
    repeat (LEVELS + 2) @(negedge clk);
  endtask

  task automatic configure(input logic [LIMIT_W-1:0] limit, input logic free_trades);
    drain_idle();
    write_reg(CFG_MAX_TRADES, limit);
    write_reg(CFG_UNLIMITED, {{(LIMIT_W-1){1'b0}}, free_trades});
  endtask

  function automatic logic [15:0] drift(input logic [15:0] from);
    int v;
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hffff;
    if (roll < 4) return 16'($urandom_range(0, 65535));
    v = int'(from);
    v = v + int'($urandom_range(0, 4000)) - 2000;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic send_sequence(output int len);
    int flaw;
    logic [15:0] price;
    logic first;
    logic last;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
    flaw = $urandom_range(0, 14);
    price = 16'($urandom_range(0, 65535));
    for (int i = 0; i < len; i++) begin
      first = (i == 0 && flaw != BREAK_NO_FIRST) || (flaw == BREAK_RESTART && i == len / 2);
      last = (i == len - 1) && (flaw != BREAK_NO_LAST);
      offer_price(price, first, last);
      price = drift(price);
    end
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] limits [10] = '{5'd0, 5'd16, 5'd31, 5'd2, 5'd17,
                                        5'd5, 5'd15, 5'd8, 5'd3, 5'd0};
    logic modes [10] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
    int sent;
    int len;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: one trade, limited
    send_price(16'd100, 1'b0, 1'b0);
    send_price(16'd40, 1'b0, 1'b0);
    send_price(16'd90, 1'b0, 1'b1);
    send_price(16'd10, 1'b0, 1'b0);
    send_price(16'hffff, 1'b1, 1'b0);
    send_price(16'd0, 1'b0, 1'b0);
    send_price(16'hffff, 1'b0, 1'b1);
    send_price(16'd0, 1'b1, 1'b1);
    send_price(16'hffff, 1'b1, 1'b0);
    send_price(16'hffff, 1'b0, 1'b0);
    send_price(16'd0, 1'b0, 1'b0);
    send_price(16'd30000, 1'b1, 1'b0);
    send_price(16'd0, 1'b0, 1'b1);

    // no trades allowed, limit above range, then unlimited
    configure(5'd0, 1'b0);
    send_price(16'd0, 1'b1, 1'b0);
    send_price(16'hffff, 1'b0, 1'b0);
    send_price(16'd0, 1'b0, 1'b0);
    send_price(16'hffff, 1'b0, 1'b1);
    configure(5'd31, 1'b0);
    send_price(16'd0, 1'b1, 1'b0);
    send_price(16'hffff, 1'b0, 1'b0);
    send_price(16'd0, 1'b0, 1'b0);
    send_price(16'hffff, 1'b0, 1'b1);
    configure(5'd31, 1'b1);
    send_price(16'd0, 1'b1, 1'b0);
    send_price(16'hffff, 1'b0, 1'b0);
    send_price(16'd0, 1'b0, 1'b0);
    send_price(16'hffff, 1'b0, 1'b1);

    // unlimited profit over full-range swings, back to back
    configure(5'd7, 1'b1);
    pace_gaps = 1'b0;
    rx_style = RX_FREE;
    for (int i = 0; i < SAT_PAIRS; i++) begin
      offer_price(16'd0, i == 0, 1'b0);
      offer_price(16'hffff, 1'b0, i == SAT_PAIRS - 1);
    end
    offer_price(16'd0, 1'b0, 1'b0);
    offer_price(16'hffff, 1'b0, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      configure(limits[ph], modes[ph]);
      rx_style = ph % 3;
      pace_gaps = (ph % 4 != 3);
      if (ph == 1 || ph == 6) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          offer_price(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          sent++;
        end else begin
          send_sequence(len);
          sent += len;
        end
      end
    end

    while (in_flight != 0) @(negedge clk);
    repeat (LEVELS + 4) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
